FILE: design/fjrr_pkg.sv
// Package for the frame job round-robin scheduler: sizes, codes and the
// controller/datapath command and status structs. No dependencies.

package fjrr_pkg;

   // Queue and field sizes
   localparam int QUEUE_DEPTH = 16;
   localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int NUM_CTX     = 8;
   localparam int NUM_STAGES  = 8;

   localparam int FUNC_W  = 2;
   localparam int CTX_W   = 3;
   localparam int TAG_W   = 8;
   localparam int FID_W   = 32;
   localparam int STAGE_W = 3;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // Input item function codes
   localparam logic [FUNC_W-1:0] FUNC_ENQ    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_STAGE  = 2'd2;

   // Result event codes
   localparam logic EV_DISPATCH = 1'b0;
   localparam logic EV_REJECT   = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCHED_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STARTED_MASK = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STAGE_MASK   = 2'd2;

   // One queued job
   typedef struct packed {
      logic [CTX_W-1:0] ctx;
      logic [TAG_W-1:0] tag;
      logic [FID_W-1:0] fid;
   } entry_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic apply;
      logic dscan;
      logic load_reject;
      logic dispatch;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic reject;
      logic can_disp;
   } status_type;

endpackage

FILE: design/fjrr_ctrl.sv
// Controller state machine of the frame job scheduler.
// Depends on fjrr_pkg for the command and status structs.

module fjrr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output fjrr_pkg::cmd_type   cmd,
   input  fjrr_pkg::status_type status
);
   import fjrr_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_OP    = 2'd1;
   localparam logic [1:0] S_DSCAN = 2'd2;
   localparam logic [1:0] S_DISP  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;
   logic       load;

   // The result register can take a new item when empty or being drained.
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequencing of one item and the commands for each step.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_OP;
            end
         end
         S_OP: begin
            if (status.reject) begin
               if (slot_free) begin
                  cmd.load_reject = 1'b1;
                  state_in        = S_IDLE;
               end
            end else begin
               cmd.apply = 1'b1;
               state_in  = S_DSCAN;
            end
         end
         S_DSCAN: begin
            cmd.dscan = 1'b1;
            state_in  = S_DISP;
         end
         S_DISP: begin
            if (!status.can_disp) begin
               state_in = S_IDLE;
            end else if (slot_free) begin
               cmd.dispatch = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result valid flag: set on a load, cleared when the item is taken.
   assign load         = cmd.load_reject || cmd.dispatch;
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: design/fjrr_datapath.sv
// Datapath of the frame job scheduler: configuration, job queue, unit
// state and result register. Depends on fjrr_pkg.

module fjrr_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [fjrr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [fjrr_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic [fjrr_pkg::FUNC_W-1:0]           req_func,
   input  logic [fjrr_pkg::CTX_W-1:0]            req_ctx_id,
   input  logic [fjrr_pkg::TAG_W-1:0]            req_frame_tag,
   input  logic [fjrr_pkg::FID_W-1:0]            req_frame_num,
   input  logic [fjrr_pkg::STAGE_W-1:0]          req_stage,
   input  fjrr_pkg::cmd_type                     cmd,
   output fjrr_pkg::status_type                  status,
   output logic                                  rsp_event_res,
   output logic [fjrr_pkg::CTX_W-1:0]            rsp_out_ctx,
   output logic [fjrr_pkg::TAG_W-1:0]            rsp_out_tag,
   output logic [fjrr_pkg::FID_W-1:0]            rsp_out_frame_num,
   output logic [fjrr_pkg::CNT_W-1:0]            rsp_pending
);
   import fjrr_pkg::*;

   // Configuration registers
   logic                  sched_mode_ff;
   logic [NUM_CTX-1:0]    started_mask_ff;
   logic [NUM_STAGES-1:0] stage_mask_ff;

   // Scheduler state
   entry_type             q_ff [QUEUE_DEPTH];
   entry_type             q_in [QUEUE_DEPTH];
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  unit_free_ff, unit_free_in;
   logic [CTX_W-1:0]      last_ctx_ff, last_ctx_in;
   logic [NUM_STAGES-1:0] done_ff, done_in;

   // Captured item and scan vectors
   logic [FUNC_W-1:0]      func_ff;
   logic [CTX_W-1:0]       ctx_ff;
   logic [TAG_W-1:0]       tag_ff;
   logic [FID_W-1:0]       fid_ff;
   logic [STAGE_W-1:0]     stage_ff;
   logic                   enabled_ff;
   logic [QUEUE_DEPTH-1:0] le_vec_ff, le_vec_in;
   logic [QUEUE_DEPTH-1:0] match_vec_ff, match_vec_in;
   logic [QUEUE_DEPTH-1:0] gt_vec_ff, gt_vec_in;

   // Result register
   logic             ev_ff;
   logic [CTX_W-1:0] out_ctx_ff;
   logic [TAG_W-1:0] out_tag_ff;
   logic [FID_W-1:0] out_fid_ff;
   logic [CNT_W-1:0] pend_ff;

   logic              le_found, match_found, gt_found;
   logic [QIDX_W-1:0] last_le_idx, match_idx, gt_idx, disp_idx, rem_pos;
   logic [CNT_W-1:0]  ins_pos;
   logic              is_enq, queue_full, do_ins, do_cancel, do_stage, do_rem;
   logic [NUM_STAGES-1:0] flags_new;
   logic              stage_complete;
   entry_type         new_entry, disp_entry;

   // Per-entry compares, each against one fixed queue slot.
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         le_vec_in[i]    = (CNT_W'(i) < count_ff) && (q_ff[i].ctx <= req_ctx_id);
         match_vec_in[i] = (CNT_W'(i) < count_ff) && (q_ff[i].tag == req_frame_tag);
         gt_vec_in[i]    = (CNT_W'(i) < count_ff) && (q_ff[i].ctx > last_ctx_ff);
      end
   end

   // Priority encoders over the registered scan vectors.
   always_comb begin
      le_found    = 1'b0;
      last_le_idx = '0;
      match_found = 1'b0;
      match_idx   = '0;
      gt_found    = 1'b0;
      gt_idx      = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (le_vec_ff[i]) begin
            le_found    = 1'b1;
            last_le_idx = QIDX_W'(i);
         end
      end
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (match_vec_ff[i]) begin
            match_found = 1'b1;
            match_idx   = QIDX_W'(i);
         end
         if (gt_vec_ff[i]) begin
            gt_found = 1'b1;
            gt_idx   = QIDX_W'(i);
         end
      end
   end

   // Decode of the operation for the captured item.
   assign is_enq     = (func_ff == FUNC_ENQ) && enabled_ff;
   assign queue_full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign do_ins     = cmd.apply && is_enq && !queue_full;
   assign do_cancel  = cmd.apply && (func_ff == FUNC_CANCEL) && match_found;
   assign do_stage   = cmd.apply && (func_ff == FUNC_STAGE) && (int'(stage_ff) < NUM_STAGES);
   assign do_rem     = do_cancel || cmd.dispatch;

   assign status.reject   = is_enq && queue_full;
   assign status.can_disp = unit_free_ff && (count_ff != '0);

   // Insert place: after the last entry of lower or equal context in
   // round-robin mode (at the head if there is none), at the tail otherwise.
   always_comb begin
      if (!sched_mode_ff) begin
         ins_pos = count_ff;
      end else if (le_found) begin
         ins_pos = CNT_W'(last_le_idx) + CNT_W'(1);
      end else begin
         ins_pos = '0;
      end
   end

   assign disp_idx   = (sched_mode_ff && gt_found) ? gt_idx : '0;
   assign rem_pos    = cmd.dispatch ? disp_idx : match_idx;
   assign disp_entry = q_ff[disp_idx];
   assign new_entry  = '{ctx: ctx_ff, tag: tag_ff, fid: fid_ff};

   // Queue shifting for insert and removal.
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_in[i] = q_ff[i];
      end
      if (do_ins) begin
         for (int i = 1; i < QUEUE_DEPTH; i++) begin
            if ((CNT_W'(i) > ins_pos) && (CNT_W'(i) <= count_ff)) begin
               q_in[i] = q_ff[i-1];
            end
         end
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (CNT_W'(i) == ins_pos) begin
               q_in[i] = new_entry;
            end
         end
      end
      if (do_rem) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            if ((CNT_W'(i) >= CNT_W'(rem_pos)) && (CNT_W'(i + 1) < count_ff)) begin
               q_in[i] = q_ff[i+1];
            end
         end
      end
   end

   // Done flags and unit state.
   assign flags_new      = done_ff | (NUM_STAGES'(1) << stage_ff);
   assign stage_complete = ((flags_new & stage_mask_ff) == stage_mask_ff);

   always_comb begin
      count_in     = count_ff;
      unit_free_in = unit_free_ff;
      last_ctx_in  = last_ctx_ff;
      done_in      = done_ff;
      if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rem) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (do_stage) begin
         if (stage_complete) begin
            unit_free_in = 1'b1;
            done_in      = '0;
         end else begin
            done_in = flags_new;
         end
      end
      if (cmd.dispatch) begin
         unit_free_in = 1'b0;
         last_ctx_in  = disp_entry.ctx;
      end
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sched_mode_ff   <= 1'b1;
         started_mask_ff <= '0;
         stage_mask_ff   <= NUM_STAGES'(1);
         count_ff        <= '0;
         unit_free_ff    <= 1'b1;
         last_ctx_ff     <= '0;
         done_ff         <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SCHED_MODE:   sched_mode_ff   <= csr_wdata[0];
               CSR_STARTED_MASK: started_mask_ff <= csr_wdata[NUM_CTX-1:0];
               CSR_STAGE_MASK:   stage_mask_ff   <= csr_wdata[NUM_STAGES-1:0];
               default: begin
               end
            endcase
         end
         count_ff     <= count_in;
         unit_free_ff <= unit_free_in;
         last_ctx_ff  <= last_ctx_in;
         done_ff      <= done_in;
      end
   end

   // Payload registers: queue, captured item, scan vectors and result.
   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
      if (cmd.capture) begin
         func_ff      <= req_func;
         ctx_ff       <= req_ctx_id;
         tag_ff       <= req_frame_tag;
         fid_ff       <= req_frame_num;
         stage_ff     <= req_stage;
         enabled_ff   <= started_mask_ff[req_ctx_id];
         le_vec_ff    <= le_vec_in;
         match_vec_ff <= match_vec_in;
      end
      if (cmd.dscan) begin
         gt_vec_ff <= gt_vec_in;
      end
      if (cmd.load_reject) begin
         ev_ff      <= EV_REJECT;
         out_ctx_ff <= ctx_ff;
         out_tag_ff <= tag_ff;
         out_fid_ff <= fid_ff;
         pend_ff    <= count_ff;
      end else if (cmd.dispatch) begin
         ev_ff      <= EV_DISPATCH;
         out_ctx_ff <= disp_entry.ctx;
         out_tag_ff <= disp_entry.tag;
         out_fid_ff <= disp_entry.fid;
         pend_ff    <= count_ff - CNT_W'(1);
      end
   end

   assign rsp_event_res     = ev_ff;
   assign rsp_out_ctx       = out_ctx_ff;
   assign rsp_out_tag       = out_tag_ff;
   assign rsp_out_frame_num = out_fid_ff;
   assign rsp_pending       = pend_ff;

endmodule

FILE: design/frame_job_round_robin_scheduler_unit.sv
// Top level of the frame job round-robin scheduler.
// Depends on fjrr_pkg, fjrr_ctrl and fjrr_datapath.
//
//   Channel   Direction  Handshake            Carries
//   req_      in         req_valid/req_stall  func, ctx_id, frame_tag, frame_num, stage
//   rsp_      out        rsp_valid/rsp_stall  event_res, out_ctx, out_tag, out_frame_num, pending
//   csr_      in         csr_wr_en            csr_index, csr_wdata
//
// An item goes through accept with the per-slot queue compares, the queue
// operation, the dispatch scan and the dispatch step; a rejected enqueue ends after the queue operation.
// The next item is accepted while a result still waits in the output register;
// a step that must load a result waits only while that register is full and stalled.
// Reset is synchronous: queue empty, unit free, done flags clear, mode round-robin.

module frame_job_round_robin_scheduler_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [fjrr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fjrr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [fjrr_pkg::FUNC_W-1:0]       req_func,
   input  logic [fjrr_pkg::CTX_W-1:0]        req_ctx_id,
   input  logic [fjrr_pkg::TAG_W-1:0]        req_frame_tag,
   input  logic [fjrr_pkg::FID_W-1:0]        req_frame_num,
   input  logic [fjrr_pkg::STAGE_W-1:0]      req_stage,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_event_res,
   output logic [fjrr_pkg::CTX_W-1:0]        rsp_out_ctx,
   output logic [fjrr_pkg::TAG_W-1:0]        rsp_out_tag,
   output logic [fjrr_pkg::FID_W-1:0]        rsp_out_frame_num,
   output logic [fjrr_pkg::CNT_W-1:0]        rsp_pending
);
   import fjrr_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer
   fjrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Queue, unit state and result register
   fjrr_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_func          (req_func),
      .req_ctx_id        (req_ctx_id),
      .req_frame_tag     (req_frame_tag),
      .req_frame_num     (req_frame_num),
      .req_stage         (req_stage),
      .cmd               (cmd),
      .status            (status),
      .rsp_event_res     (rsp_event_res),
      .rsp_out_ctx       (rsp_out_ctx),
      .rsp_out_tag       (rsp_out_tag),
      .rsp_out_frame_num (rsp_out_frame_num),
      .rsp_pending       (rsp_pending)
   );

endmodule

FILE: design/fjrr_checker.sv
// Port-level checks for the frame job scheduler, bound to the top level.
// Depends on fjrr_pkg and frame_job_round_robin_scheduler_unit.

module fjrr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_event_res,
   input logic [fjrr_pkg::CTX_W-1:0]    rsp_out_ctx,
   input logic [fjrr_pkg::TAG_W-1:0]    rsp_out_tag,
   input logic [fjrr_pkg::FID_W-1:0]    rsp_out_frame_num,
   input logic [fjrr_pkg::CNT_W-1:0]    rsp_pending
);
   import fjrr_pkg::*;

   // A stalled result item holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_res)
         && $stable(rsp_out_ctx) && $stable(rsp_out_tag)
         && $stable(rsp_out_frame_num) && $stable(rsp_pending))
      else $error("stalled result item changed");

   // An accepted item keeps the input closed on the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open right after an accepted item");

   // A rejected enqueue only happens with a full queue.
   a_reject_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_REJECT) |-> rsp_pending == CNT_W'(QUEUE_DEPTH))
      else $error("reject reported with a queue that is not full");

   // A dispatch removes one job, so fewer than a full queue remain.
   a_dispatch_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_DISPATCH) |-> rsp_pending < CNT_W'(QUEUE_DEPTH))
      else $error("dispatch reported with a full queue left");

endmodule

bind frame_job_round_robin_scheduler_unit fjrr_checker u_fjrr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_event_res     (rsp_event_res),
   .rsp_out_ctx       (rsp_out_ctx),
   .rsp_out_tag       (rsp_out_tag),
   .rsp_out_frame_num (rsp_out_frame_num),
   .rsp_pending       (rsp_pending)
);
